// ===== rtl/bit_vector_set_engine_top_assert.svh =====
// Assertion macros of the bit vector set engine.
`ifndef BIT_VECTOR_SET_ENGINE_TOP_ASSERT_SVH
`define BIT_VECTOR_SET_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BVS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bit vector set engine check failed");
`define BVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bit vector set engine sequence check failed");
`else
`define BVS_ASSERT(lbl, prop)
`define BVS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bvs_pkg.sv =====
// Types, command codes and helper functions of the bit vector set engine.
`default_nettype none
package bvs_pkg;

	typedef struct packed {
		logic [4:0]  func;
		logic [5:0]  dst_vector;
		logic [5:0]  src_a;
		logic [5:0]  src_b;
		logic [5:0]  src_c;
		logic [5:0]  src_d;
		logic [10:0] bit_index;
		logic [63:0] fill_high;
		logic [63:0] fill_low;
	} bvs_in_t;

	typedef struct packed {
		logic [11:0] bit_count;
		logic        query_flag;
		logic        index_error;
	} bvs_out_t;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 5;
	localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_BLOCKS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_LIVE_BLOCKS   = 1'b1;
	localparam logic [CFG_DATA_W-1:0]  CFG_RESET_BLOCKS  = 5'd16;

	localparam logic [4:0] F_FILL          = 5'd0;
	localparam logic [4:0] F_SET_GROW      = 5'd1;
	localparam logic [4:0] F_RESET         = 5'd2;
	localparam logic [4:0] F_GROW          = 5'd3;
	localparam logic [4:0] F_COUNT         = 5'd4;
	localparam logic [4:0] F_COPY          = 5'd5;
	localparam logic [4:0] F_COPY_NOT      = 5'd6;
	localparam logic [4:0] F_EQUAL         = 5'd7;
	localparam logic [4:0] F_EMPTY         = 5'd8;
	localparam logic [4:0] F_UNION         = 5'd9;
	localparam logic [4:0] F_INTSECT       = 5'd10;
	localparam logic [4:0] F_MINUS         = 5'd11;
	localparam logic [4:0] F_UNIONMINUS    = 5'd12;
	localparam logic [4:0] F_MINUSMINUS    = 5'd13;
	localparam logic [4:0] F_UNIONINTSECT  = 5'd14;
	localparam logic [4:0] F_UINTSECTMINUS = 5'd15;
	localparam logic [4:0] F_INTSECTUNION  = 5'd16;
	localparam logic [4:0] F_UNIONNOT      = 5'd17;
	localparam logic [4:0] F_UMINUSMINUS   = 5'd18;
	localparam logic [4:0] F_GLOP          = 5'd19;
	localparam logic [4:0] F_HOISTGLOP     = 5'd20;
	localparam logic [4:0] F_PP1           = 5'd21;
	localparam logic [4:0] F_INSERT        = 5'd22;
	localparam logic [4:0] F_SET           = 5'd23;
	localparam logic [4:0] F_CLEAR_LIVE    = 5'd24;

	// Operand usage masks: destination, sources A to D.
	localparam logic [4:0] USE_D  = 5'b00001;
	localparam logic [4:0] USE_A  = 5'b00010;
	localparam logic [4:0] USE_B  = 5'b00100;
	localparam logic [4:0] USE_C  = 5'b01000;
	localparam logic [4:0] USE_DD = 5'b10000;

	// Operand register slots filled by block reads.
	localparam logic [1:0] SLOT_A = 2'd0;
	localparam logic [1:0] SLOT_B = 2'd1;
	localparam logic [1:0] SLOT_C = 2'd2;
	localparam logic [1:0] SLOT_E = 2'd3;

	typedef enum logic [1:0] {LEN_DST, LEN_A, LEN_B} len_src_t;
	typedef enum logic [1:0] {LW_NONE, LW_GROW, LW_LIVE, LW_CLEAR} len_wr_t;
	typedef enum logic [2:0] {
		WR_NONE, WR_FILL, WR_ZERO, WR_COPY, WR_COMBINE, WR_SETBIT, WR_CLRBIT, WR_CLEAR
	} wr_kind_t;
	typedef enum logic [1:0] {ACC_NONE, ACC_COUNT, ACC_EQUAL, ACC_EMPTY} acc_kind_t;

	typedef struct packed {
		logic      capture;
		logic      len_rd;
		len_src_t  len_src;
		len_wr_t   len_wr;
		logic      rd_en;
		logic [1:0] rd_slot;
		logic      rd_dst;
		wr_kind_t  wr;
		acc_kind_t acc;
		logic      set_err;
		logic      out_load;
	} bvs_cmd_t;

	typedef struct packed {
		logic [4:0] func;
		logic       range_err;
		logic [3:0] blk_raw;
	} bvs_stat_t;

	function automatic logic [4:0] used_ops(logic [4:0] f);
		logic [4:0] u;
		case (f) inside
			F_FILL, F_SET_GROW, F_RESET, F_GROW, F_SET, F_CLEAR_LIVE: u = USE_D;
			F_COUNT, F_EMPTY: u = USE_A;
			F_COPY, F_COPY_NOT: u = USE_D | USE_A;
			F_EQUAL: u = USE_A | USE_B;
			F_UNION, F_INTSECT, F_MINUS, F_UNIONNOT: u = USE_D | USE_A | USE_B;
			F_UNIONMINUS, F_MINUSMINUS, F_UNIONINTSECT, F_INTSECTUNION, F_GLOP:
				u = USE_D | USE_A | USE_B | USE_C;
			F_UINTSECTMINUS, F_UMINUSMINUS, F_HOISTGLOP, F_PP1, F_INSERT:
				u = USE_D | USE_A | USE_B | USE_C | USE_DD;
			default: u = 5'b00000;
		endcase
		return u;
	endfunction

	function automatic logic [127:0] combine(logic [4:0] f, logic [127:0] a,
			logic [127:0] b, logic [127:0] c, logic [127:0] d);
		logic [127:0] t;
		t = a & ~b;
		case (f)
			F_UNION:         return a | b;
			F_INTSECT:       return a & b;
			F_MINUS:         return a & ~b;
			F_UNIONMINUS:    return a | (b & ~c);
			F_MINUSMINUS:    return a & ~(b & ~c);
			F_UNIONINTSECT:  return a | (b & c);
			F_UINTSECTMINUS: return a | (b & c & ~d);
			F_INTSECTUNION:  return a & (b | c);
			F_UNIONNOT:      return a | ~b;
			F_UMINUSMINUS:   return a | (b & ~c & ~d);
			F_GLOP:          return a | (b & ~c);
			F_HOISTGLOP:     return a & (b | (c & ~d));
			F_PP1:           return a & (b | (d & ~c));
			default:         return (t & ~c) | (t & d);
		endcase
	endfunction

	// Population count as a tree: byte counts, then four levels of pair sums.
	function automatic logic [7:0] popcount128(logic [127:0] v);
		logic [3:0] c8  [16];
		logic [4:0] c16 [8];
		logic [5:0] c32 [4];
		logic [6:0] c64 [2];
		for (int b = 0; b < 16; b++) begin
			c8[b] = 4'd0;
			for (int j = 0; j < 8; j++) begin
				c8[b] = c8[b] + 4'(v[b*8+j]);
			end
		end
		for (int b = 0; b < 8; b++) begin
			c16[b] = {1'b0, c8[2*b]} + {1'b0, c8[2*b+1]};
		end
		for (int b = 0; b < 4; b++) begin
			c32[b] = {1'b0, c16[2*b]} + {1'b0, c16[2*b+1]};
		end
		for (int b = 0; b < 2; b++) begin
			c64[b] = {1'b0, c32[2*b]} + {1'b0, c32[2*b+1]};
		end
		return {1'b0, c64[0]} + {1'b0, c64[1]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bit_vector_set_engine_top.sv =====
// Top level of the bit vector set engine. The engine keeps NUM_VECTORS bit vectors of up to
// MAX_BLOCKS 128-bit blocks each in one single-port-write, registered-read block memory, with
// a length in blocks per vector in a small table. Each accepted item is one command (fill,
// set, reset, grow, count, copy, copy inverted, equal, empty, clear live or a gen/kill
// combination) and yields exactly one result item. After reset the engine sweeps the memory
// and the length table to zero, one entry per cycle; configuration writes are taken during
// that time but no item is. Items are handled one at a time. For each block walked, a
// command that reads no source (fill, grow, clear live) goes straight to its write step,
// while one that does goes through four read slots on the one memory read port, a wait for
// the registered data, and then the write or accumulate step. The result sits in an output
// register, so a new item is taken while the previous result still waits.
`default_nettype none
`include "bit_vector_set_engine_top_assert.svh"
module bit_vector_set_engine_top #(
	parameter int NUM_VECTORS = 64,
	parameter int MAX_BLOCKS  = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bvs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bvs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire bvs_pkg::bvs_in_t                 in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output bvs_pkg::bvs_out_t                     out_data
);
	import bvs_pkg::*;

	localparam int VW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW = $clog2(MAX_BLOCKS + 1);

	bvs_cmd_t          cmd;
	bvs_stat_t         stat;
	logic [LW-1:0]     len;
	logic [LW-1:0]     g_grow;
	logic [LW-1:0]     g_live;
	logic [BW-1:0]     blk;
	logic [VW+BW-1:0]  sweep;

	// The controller sequences block walks; the datapath owns all storage.
	bvs_ctrl #(
		.NUM_VECTORS(NUM_VECTORS),
		.MAX_BLOCKS(MAX_BLOCKS),
		.VW(VW),
		.BW(BW),
		.LW(LW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.len(len),
		.g_grow(g_grow),
		.g_live(g_live),
		.cmd(cmd),
		.blk(blk),
		.sweep(sweep)
	);

	bvs_datapath #(
		.NUM_VECTORS(NUM_VECTORS),
		.MAX_BLOCKS(MAX_BLOCKS),
		.VW(VW),
		.BW(BW),
		.LW(LW)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.blk(blk),
		.sweep(sweep),
		.stat(stat),
		.len(len),
		.g_grow(g_grow),
		.g_live(g_live),
		.out_data(out_data)
	);

	// Once an item is taken the engine is busy until its result is registered.
	`BVS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// A result is loaded only while no new item is being captured.
	`BVS_ASSERT(a_no_load_on_capture, !(cmd.capture && cmd.out_load))
	// Loading a result always presents it on the output next cycle.
	`BVS_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid)

endmodule
`default_nettype wire

// ===== rtl/bvs_datapath.sv =====
// Datapath of the bit vector set engine: block store, length table, operands, results.
`default_nettype none
module bvs_datapath #(
	parameter int NUM_VECTORS = 64,
	parameter int MAX_BLOCKS  = 16,
	parameter int VW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1,
	parameter int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	parameter int LW = $clog2(MAX_BLOCKS + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bvs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bvs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire bvs_pkg::bvs_in_t                 in_data,
	input  wire bvs_pkg::bvs_cmd_t                cmd,
	input  wire logic [BW-1:0]                    blk,
	input  wire logic [VW+BW-1:0]                 sweep,
	output bvs_pkg::bvs_stat_t                    stat,
	output logic [LW-1:0]                         len,
	output logic [LW-1:0]                         g_grow,
	output logic [LW-1:0]                         g_live,
	output bvs_pkg::bvs_out_t                     out_data
);
	import bvs_pkg::*;

	localparam int AW    = VW + BW;
	localparam int DEPTH = NUM_VECTORS * (2 ** BW);

	bvs_in_t                item_q;
	logic [CFG_DATA_W-1:0]  vector_blocks_q;
	logic [CFG_DATA_W-1:0]  live_blocks_q;
	logic [127:0]           store_mem [DEPTH];
	logic [LW-1:0]          len_mem [NUM_VECTORS];
	logic [127:0]           rd_q;
	logic                   rd_en_s1;
	logic [1:0]             rd_slot_s1;
	logic [127:0]           op_a_q, op_b_q, op_c_q, op_e_q;
	logic [11:0]            count_q;
	logic                   flag_q;
	logic                   err_q;
	bvs_out_t               out_q;

	logic [VW-1:0]  dst_v, a_v, b_v, c_v, e_v, rd_v, len_rd_v, len_wr_v;
	logic [AW-1:0]  raddr, waddr;
	logic [127:0]   wdata, bit_mask;
	logic [LW-1:0]  len_wdata;
	logic [4:0]     used;

	assign dst_v = VW'(item_q.dst_vector);
	assign a_v   = VW'(item_q.src_a);
	assign b_v   = VW'(item_q.src_b);
	assign c_v   = VW'(item_q.src_c);
	assign e_v   = VW'(item_q.src_d);

	assign used = used_ops(item_q.func);
	assign stat.func      = item_q.func;
	assign stat.blk_raw   = item_q.bit_index[10:7];
	assign stat.range_err =
		((used & USE_D)  != 5'b0 && 32'(item_q.dst_vector) >= NUM_VECTORS) ||
		((used & USE_A)  != 5'b0 && 32'(item_q.src_a) >= NUM_VECTORS) ||
		((used & USE_B)  != 5'b0 && 32'(item_q.src_b) >= NUM_VECTORS) ||
		((used & USE_C)  != 5'b0 && 32'(item_q.src_c) >= NUM_VECTORS) ||
		((used & USE_DD) != 5'b0 && 32'(item_q.src_d) >= NUM_VECTORS);

	assign g_grow = (32'(vector_blocks_q) > MAX_BLOCKS) ? LW'(MAX_BLOCKS) : LW'(vector_blocks_q);
	assign g_live = (32'(live_blocks_q) > MAX_BLOCKS) ? LW'(MAX_BLOCKS) : LW'(live_blocks_q);

	// Bit 0 of a block is its top bit.
	assign bit_mask = 128'd1 << (7'd127 - item_q.bit_index[6:0]);

	always_comb begin
		case (cmd.rd_slot)
			SLOT_A:  rd_v = cmd.rd_dst ? dst_v : a_v;
			SLOT_B:  rd_v = b_v;
			SLOT_C:  rd_v = c_v;
			default: rd_v = e_v;
		endcase
		case (cmd.len_src)
			LEN_A:   len_rd_v = a_v;
			LEN_B:   len_rd_v = b_v;
			default: len_rd_v = dst_v;
		endcase
		case (cmd.wr)
			WR_FILL:    wdata = {item_q.fill_high, item_q.fill_low};
			WR_COPY:    wdata = (item_q.func == F_COPY_NOT) ? ~op_a_q : op_a_q;
			WR_COMBINE: wdata = combine(item_q.func, op_a_q, op_b_q, op_c_q, op_e_q);
			WR_SETBIT:  wdata = op_a_q | bit_mask;
			WR_CLRBIT:  wdata = op_a_q & ~bit_mask;
			default:    wdata = '0;
		endcase
		case (cmd.len_wr)
			LW_GROW: len_wdata = g_grow;
			LW_LIVE: len_wdata = g_live;
			default: len_wdata = '0;
		endcase
	end

	assign raddr    = {rd_v, blk};
	assign waddr    = (cmd.wr == WR_CLEAR) ? sweep : {dst_v, blk};
	assign len_wr_v = (cmd.len_wr == LW_CLEAR) ? sweep[AW-1:BW] : dst_v;

	always_ff @(posedge clk) begin
		if (cmd.wr != WR_NONE) begin
			store_mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= store_mem[raddr];
		end
		if (cmd.len_wr != LW_NONE) begin
			len_mem[len_wr_v] <= len_wdata;
		end
		if (cmd.len_rd) begin
			len <= len_mem[len_rd_v];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_blocks_q <= CFG_RESET_BLOCKS;
			live_blocks_q   <= CFG_RESET_BLOCKS;
			rd_en_s1        <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
			if (cfg_we && cfg_index == REG_VECTOR_BLOCKS) begin
				vector_blocks_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_LIVE_BLOCKS) begin
				live_blocks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= cmd.rd_slot;
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (rd_en_s1) begin
			case (rd_slot_s1)
				SLOT_A:  op_a_q <= rd_q;
				SLOT_B:  op_b_q <= rd_q;
				SLOT_C:  op_c_q <= rd_q;
				default: op_e_q <= rd_q;
			endcase
		end
		if (cmd.capture) begin
			count_q <= '0;
			flag_q  <= (in_data.func == F_EQUAL) || (in_data.func == F_EMPTY);
			err_q   <= 1'b0;
		end else if (cmd.set_err) begin
			err_q  <= 1'b1;
			flag_q <= 1'b0;
		end else begin
			case (cmd.acc)
				ACC_COUNT: count_q <= count_q + {4'd0, popcount128(op_a_q)};
				ACC_EQUAL: if (op_a_q != op_b_q) begin
					flag_q <= 1'b0;
				end
				ACC_EMPTY: if (op_a_q != '0) begin
					flag_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			out_q <= '{bit_count: count_q, query_flag: flag_q, index_error: err_q};
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== rtl/bvs_ctrl.sv =====
// Controller state machine of the bit vector set engine.
`default_nettype none
module bvs_ctrl #(
	parameter int NUM_VECTORS = 64,
	parameter int MAX_BLOCKS  = 16,
	parameter int VW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1,
	parameter int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	parameter int LW = $clog2(MAX_BLOCKS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire bvs_pkg::bvs_stat_t stat,
	input  wire logic [LW-1:0]      len,
	input  wire logic [LW-1:0]      g_grow,
	input  wire logic [LW-1:0]      g_live,
	output bvs_pkg::bvs_cmd_t       cmd,
	output logic [BW-1:0]           blk,
	output logic [VW+BW-1:0]        sweep
);
	import bvs_pkg::*;

	localparam int AW    = VW + BW;
	localparam int DEPTH = NUM_VECTORS * (2 ** BW);
	localparam int CW    = (LW > 4) ? LW : 4;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CHK, S_LEN, S_BIT, S_NEXT, S_RD, S_WAIT, S_ACT, S_DONE
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   i_q;
	logic [LW-1:0]   lim_q;
	logic [1:0]      k_q;
	logic            bit_q;
	logic            out_valid_q;
	logic [AW-1:0]   sweep_q;

	logic [4:0] used;
	logic [3:0] rd_mask;
	logic       out_free;
	logic       blk_bad;
	logic       grow_fn;

	assign used     = used_ops(stat.func);
	assign rd_mask  = bit_q ? 4'b0001 : used[4:1];
	assign out_free = !out_valid_q || !out_stall;
	assign blk_bad  = CW'(stat.blk_raw) >= CW'(lim_q);
	assign grow_fn  = (stat.func == F_GROW) || (stat.func == F_SET_GROW);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign sweep     = sweep_q;
	assign blk       = bit_q ? BW'(stat.blk_raw) : i_q[BW-1:0];

	always_comb begin
		cmd = '{capture: 1'b0, len_rd: 1'b0, len_src: LEN_DST, len_wr: LW_NONE,
			rd_en: 1'b0, rd_slot: k_q, rd_dst: bit_q, wr: WR_NONE, acc: ACC_NONE,
			set_err: 1'b0, out_load: 1'b0};
		case (state_q)
			S_CLR: begin
				cmd.wr     = WR_CLEAR;
				cmd.len_wr = LW_CLEAR;
			end
			S_IDLE: cmd.capture = in_valid;
			S_CHK: begin
				if (stat.range_err) begin
					cmd.set_err = 1'b1;
				end else begin
					cmd.len_rd = 1'b1;
					case (stat.func) inside
						[F_COUNT:F_EMPTY]: cmd.len_src = LEN_A;
						F_UNION:           cmd.len_src = LEN_B;
						default:           cmd.len_src = LEN_DST;
					endcase
				end
			end
			S_BIT: cmd.set_err = blk_bad;
			S_NEXT: begin
				if (i_q == lim_q) begin
					if (stat.func == F_CLEAR_LIVE) begin
						cmd.len_wr = LW_LIVE;
					end else if (grow_fn) begin
						cmd.len_wr = LW_GROW;
					end
				end
			end
			S_RD: cmd.rd_en = rd_mask[k_q];
			S_ACT: begin
				if (bit_q) begin
					cmd.wr = (stat.func == F_RESET) ? WR_CLRBIT : WR_SETBIT;
				end else begin
					case (stat.func) inside
						F_FILL:                             cmd.wr  = WR_FILL;
						F_GROW, F_SET_GROW, F_CLEAR_LIVE:   cmd.wr  = WR_ZERO;
						F_COPY, F_COPY_NOT:                 cmd.wr  = WR_COPY;
						F_COUNT:                            cmd.acc = ACC_COUNT;
						F_EQUAL:                            cmd.acc = ACC_EQUAL;
						F_EMPTY:                            cmd.acc = ACC_EMPTY;
						[F_UNION:F_INSERT]:                 cmd.wr  = WR_COMBINE;
						default: ;
					endcase
				end
			end
			S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			i_q         <= '0;
			lim_q       <= '0;
			k_q         <= '0;
			bit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			sweep_q     <= '0;
		end else begin
			// A finished result is presented; otherwise a taken result is dropped.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= stat.range_err ? S_DONE : S_LEN;
				S_LEN: begin
					case (stat.func) inside
						F_FILL, [F_COUNT:F_INSERT]: begin
							i_q     <= '0;
							lim_q   <= len;
							state_q <= S_NEXT;
						end
						F_GROW, F_SET_GROW: begin
							if (len < g_grow) begin
								i_q     <= len;
								lim_q   <= g_grow;
								state_q <= S_NEXT;
							end else begin
								lim_q   <= len;
								state_q <= (stat.func == F_SET_GROW) ? S_BIT : S_DONE;
							end
						end
						F_SET, F_RESET: begin
							lim_q   <= len;
							state_q <= S_BIT;
						end
						F_CLEAR_LIVE: begin
							i_q     <= '0;
							lim_q   <= g_live;
							state_q <= S_NEXT;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_BIT: begin
					if (blk_bad) begin
						state_q <= S_DONE;
					end else begin
						bit_q   <= 1'b1;
						k_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_NEXT: begin
					if (i_q == lim_q) begin
						state_q <= (stat.func == F_SET_GROW) ? S_BIT : S_DONE;
					end else if (rd_mask == 4'b0000) begin
						state_q <= S_ACT;
					end else begin
						k_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					k_q <= k_q + 1'b1;
					if (k_q == SLOT_E) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_ACT;
				S_ACT: begin
					if (bit_q) begin
						bit_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the bit vector set engine, with its own command predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import bvs_pkg::*;

	// The clock, the reset and every input of the engine start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	bvs_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bvs_out_t out_data;

	bit_vector_set_engine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Shadow copy of the engine: every vector as 16 blocks of 128 bits, where bit p
	// of a vector lands at position 127 - (p & 127) of block p >> 7.
	logic [127:0] shadow_bits [64][16];
	logic [4:0] shadow_len [64];
	logic [4:0] grow_blocks = 5'd16;
	logic [4:0] live_len = 5'd16;

	bvs_in_t pending_cmds [$];
	bvs_out_t expected_results [$];

	int cmds_taken = 0;
	int results_checked = 0;
	int mismatches = 0;
	int range_flags = 0;
	int query_hits = 0;
	int hold_requests = 0;

	function automatic logic [4:0] clamp_len(logic [4:0] v);
		return (v > 5'd16) ? 5'd16 : v;
	endfunction

	// Applies one command to the shadow store and returns the result it should give.
	function automatic bvs_out_t apply_command(bvs_in_t c);
		bvs_out_t r;
		logic [127:0] mask, a, b, x, d, t, y;
		logic [4:0] g;
		int blk, n, pop;
		r = '0;
		blk = c.bit_index[10:7];
		mask = 128'd1 << (127 - c.bit_index[6:0]);
		case (c.func)
			F_FILL: begin
				for (int i = 0; i < shadow_len[c.dst_vector]; i++)
					shadow_bits[c.dst_vector][i] = {c.fill_high, c.fill_low};
			end
			F_SET_GROW, F_GROW, F_SET: begin
				if (c.func != F_SET) begin
					g = clamp_len(grow_blocks);
					if (shadow_len[c.dst_vector] < g) begin
						for (int i = shadow_len[c.dst_vector]; i < g; i++)
							shadow_bits[c.dst_vector][i] = '0;
						shadow_len[c.dst_vector] = g;
					end
				end
				if (c.func != F_GROW) begin
					if (blk >= shadow_len[c.dst_vector])
						r.index_error = 1'b1;
					else
						shadow_bits[c.dst_vector][blk] |= mask;
				end
			end
			F_RESET: begin
				if (blk >= shadow_len[c.dst_vector])
					r.index_error = 1'b1;
				else
					shadow_bits[c.dst_vector][blk] &= ~mask;
			end
			F_COUNT: begin
				pop = 0;
				for (int i = 0; i < shadow_len[c.src_a]; i++)
					pop += $countones(shadow_bits[c.src_a][i]);
				r.bit_count = pop[11:0];
			end
			F_COPY, F_COPY_NOT: begin
				for (int i = 0; i < shadow_len[c.src_a]; i++) begin
					y = shadow_bits[c.src_a][i];
					shadow_bits[c.dst_vector][i] = (c.func == F_COPY_NOT) ? ~y : y;
				end
			end
			F_EQUAL: begin
				r.query_flag = 1'b1;
				for (int i = 0; i < shadow_len[c.src_a]; i++)
					if (shadow_bits[c.src_a][i] != shadow_bits[c.src_b][i])
						r.query_flag = 1'b0;
			end
			F_EMPTY: begin
				r.query_flag = 1'b1;
				for (int i = 0; i < shadow_len[c.src_a]; i++)
					if (shadow_bits[c.src_a][i] != '0)
						r.query_flag = 1'b0;
			end
			F_CLEAR_LIVE: begin
				g = clamp_len(live_len);
				for (int i = 0; i < g; i++)
					shadow_bits[c.dst_vector][i] = '0;
				shadow_len[c.dst_vector] = g;
			end
			default: begin
				if (c.func >= F_UNION && c.func <= F_INSERT) begin
					n = (c.func == F_UNION) ? shadow_len[c.src_b] : shadow_len[c.dst_vector];
					for (int i = 0; i < n; i++) begin
						// All four sources are read before the destination block is written.
						a = shadow_bits[c.src_a][i];
						b = shadow_bits[c.src_b][i];
						x = shadow_bits[c.src_c][i];
						d = shadow_bits[c.src_d][i];
						t = a & ~b;
						case (c.func)
							F_UNION:         y = a | b;
							F_INTSECT:       y = a & b;
							F_MINUS:         y = t;
							F_UNIONMINUS:    y = a | (b & ~x);
							F_MINUSMINUS:    y = a & ~(b & ~x);
							F_UNIONINTSECT:  y = a | (b & x);
							F_UINTSECTMINUS: y = a | (b & x & ~d);
							F_INTSECTUNION:  y = a & (b | x);
							F_UNIONNOT:      y = a | ~b;
							F_UMINUSMINUS:   y = a | (b & ~x & ~d);
							F_GLOP:          y = a | (b & ~x);
							F_HOISTGLOP:     y = a & (b | (x & ~d));
							F_PP1:           y = a & (b | (d & ~x));
							default:         y = (t & ~x) | (t & d);
						endcase
						shadow_bits[c.dst_vector][i] = y;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Builds one item. Most use a small pool of vectors so that commands act on each
	// other's results; a few range over every vector number and every field bit.
	function automatic bvs_in_t make_command(logic [4:0] f, bit wide);
		bvs_in_t c;
		c = '0;
		c.func = f;
		c.dst_vector = wide ? 6'($urandom) : 6'($urandom_range(0, 7));
		c.src_a = wide ? 6'($urandom) : 6'($urandom_range(0, 7));
		c.src_b = wide ? 6'($urandom) : 6'($urandom_range(0, 7));
		c.src_c = wide ? 6'($urandom) : 6'($urandom_range(0, 7));
		c.src_d = wide ? 6'($urandom) : 6'($urandom_range(0, 7));
		if ($urandom_range(0, 3) == 0)
			c.src_a = c.dst_vector;
		c.bit_index = ($urandom_range(0, 2) == 0) ? 11'($urandom)
			: 11'($urandom_range(0, 16 * clamp_len(grow_blocks) - 1));
		case ($urandom_range(0, 5))
			0: {c.fill_high, c.fill_low} = '1;
			1: {c.fill_high, c.fill_low} = '0;
			default: {c.fill_high, c.fill_low} = {$urandom, $urandom, $urandom, $urandom};
		endcase
		return c;
	endfunction

	function automatic logic [4:0] random_func();
		case ($urandom_range(0, 19))
			0, 1, 2: return F_SET_GROW;
			3, 4: return F_SET;
			5: return F_RESET;
			6: return F_GROW;
			7: return F_FILL;
			8: return F_COUNT;
			9: return ($urandom_range(0, 1) == 0) ? F_COPY : F_COPY_NOT;
			10: return ($urandom_range(0, 1) == 0) ? F_EQUAL : F_EMPTY;
			11: return F_CLEAR_LIVE;
			12: return 5'($urandom_range(25, 31));
			default: return 5'($urandom_range(9, 22));
		endcase
	endfunction

	// Sender: items go out in bursts of random length separated by random gaps.
	// A payload only changes when the previous one was taken or none was offered.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				in_data <= pending_cmds.pop_front();
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
					gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Every accepted item is run through the predictor at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(apply_command(in_data));
			cmds_taken++;
		end
	end

	// Receiver: the stall pattern is redrawn at random whenever its phase counter wraps, and on
	// request it holds off for a long stretch so the engine backs up into its input.
	int stall_mode = 0;
	int stall_phase = 0;
	int hold_left = 0;
	int holds_done = 0;
	always @(posedge clk) begin
		if (holds_done < hold_requests) begin
			holds_done = holds_done + 1;
			hold_left = 800;
		end
		stall_phase = stall_phase + 1;
		if (stall_phase == 64) begin
			stall_phase = 0;
			stall_mode = $urandom_range(0, 3);
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 9) == 0);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Checker: each result is compared with the oldest prediction.
	always @(posedge clk) begin
		bvs_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: result %p arrived with nothing expected", out_data);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.index_error) range_flags++;
				if (want.query_flag) query_hits++;
				if (out_data.bit_count !== want.bit_count ||
					out_data.query_flag !== want.query_flag ||
					out_data.index_error !== want.index_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("error: result %0d count %0d/%0d flag %0b/%0b err %0b/%0b (exp/act)",
							results_checked, want.bit_count, out_data.bit_count,
							want.query_flag, out_data.query_flag,
							want.index_error, out_data.index_error);
				end
			end
		end
	end

	// Waits until every queued item was taken and every result came back, then lets
	// the engine settle before anything touches its registers.
	task automatic drain_engine();
		while (pending_cmds.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [4:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_VECTOR_BLOCKS)
			grow_blocks = value;
		else
			live_len = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_command(logic [4:0] f, logic [5:0] dv, logic [5:0] av,
			logic [5:0] bv, logic [10:0] bit_pos);
		bvs_in_t c;
		c = make_command(f, 1'b0);
		c.dst_vector = dv;
		c.src_a = av;
		c.src_b = bv;
		c.bit_index = bit_pos;
		pending_cmds.push_back(c);
	endtask

	// Settings per phase: reset values, then the extremes, a value above the
	// block limit (it clamps), zero and random lengths.
	logic [4:0] grow_plan [6] = '{5'd16, 5'd1, 5'd16, 5'd31, 5'd0, 5'd5};
	logic [4:0] live_plan [6] = '{5'd16, 5'd16, 5'd1, 5'd3, 5'd31, 5'd9};

	initial begin
		for (int v = 0; v < 64; v++) begin
			shadow_len[v] = '0;
			for (int i = 0; i < 16; i++)
				shadow_bits[v][i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: queries on never-grown vectors, set errors, bit 0 and
		// bit 2047, a full count, copies, every combination and an unused code.
		add_command(F_COUNT, 0, 0, 0, 0);
		add_command(F_EMPTY, 0, 0, 0, 0);
		add_command(F_EQUAL, 0, 0, 1, 0);
		add_command(F_SET, 0, 0, 0, 5);
		add_command(F_RESET, 0, 0, 0, 2047);
		add_command(F_GROW, 1, 0, 0, 0);
		add_command(F_SET_GROW, 2, 0, 0, 11'd2047);
		add_command(F_SET, 2, 0, 0, 0);
		add_command(F_RESET, 2, 0, 0, 0);
		add_command(F_FILL, 2, 0, 0, 0);
		pending_cmds[$].fill_high = '1;
		pending_cmds[$].fill_low = '1;
		add_command(F_COUNT, 0, 2, 0, 0);
		add_command(F_COPY, 3, 2, 0, 0);
		add_command(F_COPY_NOT, 4, 2, 0, 0);
		add_command(F_EQUAL, 0, 2, 3, 0);
		add_command(F_EMPTY, 0, 4, 0, 0);
		add_command(F_SET_GROW, 5, 0, 0, 11'd700);
		for (int f = F_UNION; f <= F_INSERT; f++)
			add_command(5'(f), 6'($urandom_range(3, 6)), 6'($urandom_range(1, 5)),
				6'($urandom_range(1, 5)), 0);
		add_command(F_CLEAR_LIVE, 2, 0, 0, 0);
		add_command(5'd31, 63, 63, 63, 11'd2047);

		for (int ph = 0; ph < 6; ph++) begin
			drain_engine();
			write_register(REG_VECTOR_BLOCKS, grow_plan[ph]);
			write_register(REG_LIVE_BLOCKS, live_plan[ph]);
			// In the third phase the receiver holds off while items keep coming.
			if (ph == 2)
				hold_requests = hold_requests + 1;
			for (int k = 0; k < 65; k++)
				pending_cmds.push_back(make_command(random_func(),
					$urandom_range(0, 9) == 0));
		end
		drain_engine();

		$display("Checked %0d results of %0d commands over six register settings,",
			results_checked, cmds_taken);
		$display("  %0d with an index error and %0d with a true query answer.",
			range_flags, query_hits);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(12 * 1500000);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
